>>> src/itr_pkg.sv
`timescale 1ns / 1ps

package itr_pkg;

    localparam int VALUE_W  = 12;
    localparam int CHAR_W   = 8;
    localparam int KVAL_W   = 10;
    localparam int STEP_W   = 5;
    localparam int PROG_LEN = 19;

    localparam logic [CHAR_W-1:0] LETTER_M = 8'h4D;
    localparam logic [CHAR_W-1:0] LETTER_D = 8'h44;
    localparam logic [CHAR_W-1:0] LETTER_C = 8'h43;
    localparam logic [CHAR_W-1:0] LETTER_L = 8'h4C;
    localparam logic [CHAR_W-1:0] LETTER_X = 8'h58;
    localparam logic [CHAR_W-1:0] LETTER_V = 8'h56;
    localparam logic [CHAR_W-1:0] LETTER_I = 8'h49;

    // One microcode word. A plain step tests rem >= kval, emits and subtracts.
    // A pair_first step tests and emits without subtracting; the following
    // pair_second step emits unconditionally and subtracts.
    typedef struct packed {
        logic [KVAL_W-1:0] kval;
        logic [CHAR_W-1:0] letter;
        logic              pair_first;
        logic              pair_second;
        logic [STEP_W-1:0] jmp_pass;
        logic [STEP_W-1:0] jmp_fail;
    } t_uword;

    typedef struct packed {
        logic ge;
        logic eq;
    } t_dp_status;

endpackage

>>> src/integer_to_roman_numeral_core.sv
`timescale 1ns / 1ps
// After start is taken, the core runs one microcode step per cycle while
// busy, and a step emits one letter or fails one test; letters are strobed
// from registers. Start is taken only while busy is low, so a new value
// waits for the last letter of the run; zero emits no letters, busy stays low.
// Reset (synchronous, active low) clears busy, the step counter and the strobe.
// Results are strobed for one cycle each; the receiver cannot stall.
module integer_to_roman_numeral_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [itr_pkg::VALUE_W-1:0] i_value,
    output logic                        o_strobe,
    output logic [itr_pkg::CHAR_W-1:0]  o_numeral_char,
    output logic                        o_last_char
);
    import itr_pkg::*;

    logic               r_busy, n_busy;
    logic [STEP_W-1:0]  r_step, n_step;
    logic               r_strobe, n_strobe;
    logic [CHAR_W-1:0]  r_char, n_char;
    logic               r_last, n_last;
    logic               load;
    logic               sub;
    t_uword             uword;
    t_dp_status         dp_status;

    assign load = start && !r_busy;

    itr_ucode_rom u_rom (
        .i_step  (r_step),
        .o_uword (uword)
    );

    itr_datapath u_dp (
        .i_clk    (i_clk),
        .i_load   (load),
        .i_value  (i_value),
        .i_sub    (sub),
        .i_kval   (uword.kval),
        .o_status (dp_status)
    );

    always_comb begin
        n_busy   = r_busy;
        n_step   = r_step;
        n_strobe = 1'b0;
        n_char   = uword.letter;
        n_last   = 1'b0;
        sub      = 1'b0;
        if (load) begin
            n_busy = (i_value != '0);
            n_step = '0;
        end else if (r_busy) begin
            if (uword.pair_second || dp_status.ge) begin
                n_strobe = 1'b1;
                n_step   = uword.jmp_pass;
                if (!uword.pair_first) begin
                    // finish the token: subtract and flag the end of the run
                    sub    = 1'b1;
                    n_last = dp_status.eq;
                    if (dp_status.eq) begin
                        n_busy = 1'b0;
                    end
                end
            end else begin
                n_step = uword.jmp_fail;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_step   <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_busy   <= n_busy;
            r_step   <= n_step;
            r_strobe <= n_strobe;
        end
        r_char <= n_char;
        r_last <= n_last;
    end

    assign busy           = r_busy;
    assign o_strobe       = r_strobe;
    assign o_numeral_char = r_char;
    assign o_last_char    = r_last;

endmodule

>>> src/itr_ucode_rom.sv
`timescale 1ns / 1ps

module itr_ucode_rom (
    input  logic [itr_pkg::STEP_W-1:0] i_step,
    output itr_pkg::t_uword            o_uword
);
    import itr_pkg::*;

    function automatic t_uword mk(input int unsigned k, input logic [CHAR_W-1:0] ch,
                                  input logic pf, input logic ps,
                                  input int unsigned pass, input int unsigned fail);
        t_uword w;
        w.kval        = KVAL_W'(k);
        w.letter      = ch;
        w.pair_first  = pf;
        w.pair_second = ps;
        w.jmp_pass    = STEP_W'(pass);
        w.jmp_fail    = STEP_W'(fail);
        return w;
    endfunction

    always_comb begin
        case (i_step)
            5'd0:    o_uword = mk(1000, LETTER_M, 1'b0, 1'b0,  0,  1);
            5'd1:    o_uword = mk( 900, LETTER_C, 1'b1, 1'b0,  2,  3);
            5'd2:    o_uword = mk( 900, LETTER_M, 1'b0, 1'b1,  3,  3);
            5'd3:    o_uword = mk( 500, LETTER_D, 1'b0, 1'b0,  4,  4);
            5'd4:    o_uword = mk( 400, LETTER_C, 1'b1, 1'b0,  5,  6);
            5'd5:    o_uword = mk( 400, LETTER_D, 1'b0, 1'b1,  6,  6);
            5'd6:    o_uword = mk( 100, LETTER_C, 1'b0, 1'b0,  6,  7);
            5'd7:    o_uword = mk(  90, LETTER_X, 1'b1, 1'b0,  8,  9);
            5'd8:    o_uword = mk(  90, LETTER_C, 1'b0, 1'b1,  9,  9);
            5'd9:    o_uword = mk(  50, LETTER_L, 1'b0, 1'b0, 10, 10);
            5'd10:   o_uword = mk(  40, LETTER_X, 1'b1, 1'b0, 11, 12);
            5'd11:   o_uword = mk(  40, LETTER_L, 1'b0, 1'b1, 12, 12);
            5'd12:   o_uword = mk(  10, LETTER_X, 1'b0, 1'b0, 12, 13);
            5'd13:   o_uword = mk(   9, LETTER_I, 1'b1, 1'b0, 14, 15);
            5'd14:   o_uword = mk(   9, LETTER_X, 1'b0, 1'b1, 15, 15);
            5'd15:   o_uword = mk(   5, LETTER_V, 1'b0, 1'b0, 16, 16);
            5'd16:   o_uword = mk(   4, LETTER_I, 1'b1, 1'b0, 17, 18);
            5'd17:   o_uword = mk(   4, LETTER_V, 1'b0, 1'b1, 18, 18);
            5'd18:   o_uword = mk(   1, LETTER_I, 1'b0, 1'b0, 18, 18);
            default: o_uword = mk(   1, LETTER_I, 1'b0, 1'b0, 18, 18);
        endcase
    end

endmodule

>>> src/itr_datapath.sv
`timescale 1ns / 1ps

module itr_datapath (
    input  logic                        i_clk,
    input  logic                        i_load,
    input  logic [itr_pkg::VALUE_W-1:0] i_value,
    input  logic                        i_sub,
    input  logic [itr_pkg::KVAL_W-1:0]  i_kval,
    output itr_pkg::t_dp_status         o_status
);
    import itr_pkg::*;

    logic [VALUE_W-1:0] r_rem;
    logic [VALUE_W-1:0] n_rem;
    logic [VALUE_W-1:0] kext;

    assign kext        = VALUE_W'(i_kval);
    assign o_status.ge = (r_rem >= kext);
    assign o_status.eq = (r_rem == kext);

    always_comb begin
        n_rem = r_rem;
        if (i_load) begin
            n_rem = i_value;
        end else if (i_sub) begin
            n_rem = r_rem - kext;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
    end

endmodule

>>> dv/integer_to_roman_numeral_core_tb.sv
`timescale 1ns / 1ps

module integer_to_roman_numeral_core_tb;
    import itr_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 40;
    localparam int N_RANDOM = 105;
    localparam int N_DIRECTED = 25;
    localparam int unsigned DIRECTED_VALUES [N_DIRECTED] = '{
        0, 1, 4, 5, 9, 10, 40, 49, 90, 99, 400, 444, 500, 900, 999,
        1000, 1994, 3888, 3999, 4000, 4088, 4095, 2048, 1365, 2730
    };

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              is_last;
    } t_letter;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [VALUE_W-1:0] i_value = '0;
    logic               o_strobe;
    logic [CHAR_W-1:0]  o_numeral_char;
    logic               o_last_char;

    logic [VALUE_W-1:0] values_pending[$];
    t_letter            letters_due[$];

    int err_cnt = 0;
    int values_taken = 0;
    int zeros_taken = 0;
    int big_taken = 0;
    int letters_seen = 0;
    int cycle_cnt = 0;
    int gap_left = 0;
    int burst_left = 0;

    integer_to_roman_numeral_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_value        (i_value),
        .o_strobe       (o_strobe),
        .o_numeral_char (o_numeral_char),
        .o_last_char    (o_last_char)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        if (err_cnt < 40) begin
            $display("[%0t] MISMATCH: %s", $realtime, msg);
        end
        err_cnt++;
    endtask

    // Queue the letters of one numeral, most significant first.
    task automatic expect_numeral(input logic [VALUE_W-1:0] v);
        logic [CHAR_W-1:0] seq[$];
        logic [CHAR_W-1:0] unit;
        logic [CHAR_W-1:0] half;
        logic [CHAR_W-1:0] upper;
        int unsigned rest;
        int unsigned d;
        int unsigned k;
        rest = v;
        for (k = 0; k < rest / 1000; k++) seq.push_back(LETTER_M);
        rest = rest % 1000;
        for (int pos = 0; pos < 3; pos++) begin
            case (pos)
                0: begin
                    unit = LETTER_C; half = LETTER_D; upper = LETTER_M; d = rest / 100;
                end
                1: begin
                    unit = LETTER_X; half = LETTER_L; upper = LETTER_C; d = (rest / 10) % 10;
                end
                default: begin
                    unit = LETTER_I; half = LETTER_V; upper = LETTER_X; d = rest % 10;
                end
            endcase
            if (d == 9) begin
                seq.push_back(unit);
                seq.push_back(upper);
            end else if (d == 4) begin
                seq.push_back(unit);
                seq.push_back(half);
            end else begin
                if (d >= 5) begin
                    seq.push_back(half);
                    d -= 5;
                end
                for (k = 0; k < d; k++) seq.push_back(unit);
            end
        end
        for (k = 0; k < seq.size(); k++) begin
            letters_due.push_back('{ch: seq[k], is_last: (k + 1 == seq.size())});
        end
    endtask

    // Mostly short gaps, a few long ones, and runs of back-to-back beats.
    function automatic int pick_gap();
        int r;
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        if ($urandom_range(7) == 0) begin
            burst_left = $urandom_range(20, 8);
            return 0;
        end
        r = $urandom_range(99);
        if (r < 40) return 0;
        if (r < 85) return $urandom_range(3, 1);
        if (r < 95) return $urandom_range(10, 4);
        return $urandom_range(60, 20);
    endfunction

    function automatic logic [VALUE_W-1:0] pick_value();
        int r;
        r = $urandom_range(19);
        if (r == 0) return '0;
        if (r == 1) return VALUE_W'($urandom_range(4095, 4000));
        if (r <= 4) return VALUE_W'($urandom_range(99, 1));
        if (r == 5) return VALUE_W'($urandom);
        return VALUE_W'($urandom_range(3999, 1));
    endfunction

    always @(posedge i_clk) begin : drive_values
        logic go;
        if (!i_rst_n) begin
            start <= 1'b0;
            i_value <= '0;
        end else begin
            go = start;
            if (start && !busy) begin
                expect_numeral(i_value);
                values_taken++;
                if (i_value == 0) zeros_taken++;
                if (i_value > 3999) big_taken++;
                void'(values_pending.pop_front());
                go = 1'b0;
                gap_left = pick_gap();
            end
            if (!go) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (values_pending.size() > 0) begin
                    go = 1'b1;
                    i_value <= values_pending[0];
                end
            end
            start <= go;
        end
    end

    always @(posedge i_clk) begin : watch_letters
        t_letter want;
        if (i_rst_n && o_strobe) begin
            letters_seen++;
            if (letters_due.size() == 0) begin
                report_mismatch($sformatf("letter 0x%02h with nothing pending", o_numeral_char));
            end else begin
                want = letters_due.pop_front();
                if (o_numeral_char !== want.ch) begin
                    report_mismatch($sformatf("letter 0x%02h, want 0x%02h",
                                              o_numeral_char, want.ch));
                end
                if (o_last_char !== want.is_last) begin
                    report_mismatch($sformatf("last flag %b, want %b",
                                              o_last_char, want.is_last));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d letters outstanding",
                     cycle_cnt, letters_due.size());
            $display("integer_to_roman_numeral_core_tb: FAIL");
            $finish;
        end
    end

    initial begin
        for (int n = 0; n < N_DIRECTED; n++) begin
            values_pending.push_back(VALUE_W'(DIRECTED_VALUES[n]));
        end
        for (int n = 0; n < N_RANDOM; n++) begin
            values_pending.push_back(pick_value());
        end
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (values_pending.size() != 0 || start || letters_due.size() != 0) begin
            @(posedge i_clk);
        end
        // hold for a late or stray beat after the last expected letter
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (letters_due.size() != 0) report_mismatch("letters still pending at end of run");
        $display("converted %0d values (%0d zero, %0d above 3999), checked %0d letters",
                 values_taken, zeros_taken, big_taken, letters_seen);
        $display("mismatches: %0d", err_cnt);
        if (err_cnt == 0) begin
            $display("integer_to_roman_numeral_core_tb: PASS");
        end else begin
            $display("integer_to_roman_numeral_core_tb: FAIL");
        end
        $finish;
    end

endmodule
